>>> rtl/pir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pir_pkg;

   // Number of characters in one pass, 2 to 256.
   localparam int ALPHABET = 256;

   localparam int CLASS_W = 8;
   localparam int KEY_W   = 2 * CLASS_W;
   localparam int ID_W    = 8;
   localparam int COUNT_W = 9;
   localparam int POS_W   = 8;
   localparam int REV_DEPTH = 1 << ID_W;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(ALPHABET - 1);

   typedef logic [CLASS_W-1:0] class_type;
   typedef logic [KEY_W-1:0]   key_type;
   typedef logic [ID_W-1:0]    id_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [POS_W-1:0]   pos_type;

   // Write request into the pair table.
   typedef struct packed {
      logic    en;
      key_type addr;
      id_type  data;
   } pair_wr_type;

   // Write request into the reverse (id to pair) table.
   typedef struct packed {
      logic    en;
      id_type  addr;
      key_type data;
   } rev_wr_type;

   // A recent insertion, kept for forwarding.
   typedef struct packed {
      logic    valid;
      key_type key;
      id_type  id;
   } insert_type;

endpackage

`default_nettype wire

>>> rtl/pir_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pir_req_if;
   logic                valid;
   logic                ready;
   pir_pkg::class_type  own_class;
   pir_pkg::class_type  other_class;

   modport source (output valid, output own_class, output other_class, input ready);
   modport sink   (input valid, input own_class, input other_class, output ready);
endinterface

interface pir_rsp_if;
   logic                valid;
   logic                ready;
   pir_pkg::id_type     merged_class;
   pir_pkg::count_type  class_count;
   logic                last;

   modport source (output valid, output merged_class, output class_count, output last,
                   input ready);
   modport sink   (input valid, input merged_class, input class_count, input last,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/partition_intersect_renumber.sv
`timescale 1ns / 1ps
`default_nettype none

// Intersects two partitions of a byte alphabet and renumbers the classes densely.
// The req_ch channel takes one transaction per character, characters in order
// 0..ALPHABET-1, each carrying the class in both partitions. The rsp_ch channel
// returns one transaction per character: its intersection class, the class count
// so far and a last flag on the final character, after which the next pass begins.
// A result passes through the p1, p2 and output registers before rsp_ch.valid rises;
// the block takes one transaction every cycle while rsp_ch is not stalled and no
// clearing pass runs, since each character needs one read of the pair table, one
// read of the id table and one conditional write of each.
// The pair table is never cleared between passes: an entry counts only if its id
// is below the live class count and the id table maps that id back to the pair.
// After reset a clearing pass writes all 65536 pair entries, one per cycle, so
// req_ch.ready stays low until the clearing pass is done.
// When rsp_ch stalls with a result waiting, the whole pipeline holds and
// req_ch.ready falls; a result waiting in the output register does not stop the
// next transaction while the receiver is ready.
module partition_intersect_renumber (
   input  wire logic  clock,
   input  wire logic  reset,
   pir_req_if.sink    req_ch,
   pir_rsp_if.source  rsp_ch
);
   import pir_pkg::*;

   logic        clearing_ff, clearing_in;
   key_type     clr_addr_ff, clr_addr_in;

   logic        adv;
   logic        accept;
   logic        commit;

   pos_type     pos_ff, pos_in;

   logic        p1_valid_ff, p1_valid_in;
   key_type     p1_key_ff;
   logic        p1_last_ff;

   logic        p2_valid_ff, p2_valid_in;
   key_type     p2_key_ff;
   logic        p2_last_ff;
   id_type      p2_id_ff;

   id_type      pair_q;
   key_type     rev_q;

   insert_type  h1_ff, h1_in, h2_ff, h2_in;
   count_type   next_class_ff, next_class_in;

   logic        out_valid_ff, out_valid_in;
   id_type      out_id_ff;
   count_type   out_count_ff;
   logic        out_last_ff;

   logic        fwd1, fwd2, mem_hit, hit;
   id_type      hit_id, res_id;
   count_type   res_count;

   pair_wr_type pair_wr;
   rev_wr_type  rev_wr;

   assign adv    = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv && !clearing_ff;
   assign accept = req_ch.valid && req_ch.ready;
   assign commit = adv && p2_valid_ff;

   // Lookup decision for the character in the second stage. The two most recent
   // insertions are not yet visible in the data read from the tables.
   always_comb begin
      fwd1    = h1_ff.valid && (h1_ff.key == p2_key_ff);
      fwd2    = h2_ff.valid && (h2_ff.key == p2_key_ff);
      mem_hit = ({1'b0, p2_id_ff} < next_class_ff) && (rev_q == p2_key_ff)
                && !(h1_ff.valid && (h1_ff.id == p2_id_ff));
      hit     = fwd1 || fwd2 || mem_hit;
      if (fwd1) begin
         hit_id = h1_ff.id;
      end else if (fwd2) begin
         hit_id = h2_ff.id;
      end else begin
         hit_id = p2_id_ff;
      end
      res_id    = hit ? hit_id : next_class_ff[ID_W-1:0];
      res_count = hit ? next_class_ff : next_class_ff + COUNT_W'(1);
   end

   always_comb begin
      pair_wr.en   = 1'b0;
      pair_wr.addr = p2_key_ff;
      pair_wr.data = next_class_ff[ID_W-1:0];
      rev_wr.en    = 1'b0;
      rev_wr.addr  = next_class_ff[ID_W-1:0];
      rev_wr.data  = p2_key_ff;
      if (clearing_ff) begin
         pair_wr.en   = 1'b1;
         pair_wr.addr = clr_addr_ff;
         pair_wr.data = '0;
         rev_wr.en    = 1'b1;
         rev_wr.addr  = clr_addr_ff[ID_W-1:0];
         rev_wr.data  = '0;
      end else if (commit && !hit) begin
         pair_wr.en = 1'b1;
         rev_wr.en  = 1'b1;
      end
   end

   always_comb begin
      clearing_in   = clearing_ff && (clr_addr_ff != '1);
      clr_addr_in   = clearing_ff ? clr_addr_ff + KEY_W'(1) : clr_addr_ff;
      pos_in        = pos_ff;
      p1_valid_in   = p1_valid_ff;
      p2_valid_in   = p2_valid_ff;
      out_valid_in  = out_valid_ff;
      next_class_in = next_class_ff;
      h1_in         = h1_ff;
      h2_in         = h2_ff;
      if (accept) begin
         pos_in = (pos_ff == LAST_POS) ? '0 : pos_ff + POS_W'(1);
      end
      if (adv) begin
         p1_valid_in  = accept;
         p2_valid_in  = p1_valid_ff;
         out_valid_in = p2_valid_ff;
         h1_in.valid  = commit && !hit;
         h1_in.key    = p2_key_ff;
         h1_in.id     = next_class_ff[ID_W-1:0];
         h2_in        = h1_ff;
         if (commit) begin
            next_class_in = p2_last_ff ? '0 : res_count;
            if (p2_last_ff) begin
               h1_in.valid = 1'b0;
               h2_in.valid = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clr_addr_ff   <= '0;
         pos_ff        <= '0;
         p1_valid_ff   <= 1'b0;
         p2_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         next_class_ff <= '0;
         h1_ff         <= '0;
         h2_ff         <= '0;
      end else begin
         clearing_ff   <= clearing_in;
         clr_addr_ff   <= clr_addr_in;
         pos_ff        <= pos_in;
         p1_valid_ff   <= p1_valid_in;
         p2_valid_ff   <= p2_valid_in;
         out_valid_ff  <= out_valid_in;
         next_class_ff <= next_class_in;
         h1_ff         <= h1_in;
         h2_ff         <= h2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_key_ff    <= {req_ch.own_class, req_ch.other_class};
         p1_last_ff   <= (pos_ff == LAST_POS);
         p2_key_ff    <= p1_key_ff;
         p2_last_ff   <= p1_last_ff;
         p2_id_ff     <= pair_q;
         out_id_ff    <= res_id;
         out_count_ff <= res_count;
         out_last_ff  <= p2_last_ff;
      end
   end

   pir_pair_mem u_pair_mem (
      .clock   (clock),
      .rd_en   (adv),
      .rd_addr ({req_ch.own_class, req_ch.other_class}),
      .rd_data (pair_q),
      .wr      (pair_wr)
   );

   pir_rev_mem u_rev_mem (
      .clock   (clock),
      .rd_en   (adv),
      .rd_addr (pair_q),
      .rd_data (rev_q),
      .wr      (rev_wr)
   );

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.merged_class = out_id_ff;
   assign rsp_ch.class_count  = out_count_ff;
   assign rsp_ch.last         = out_last_ff;

endmodule

`default_nettype wire

>>> rtl/pir_pair_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module pir_pair_mem (
   input  wire logic                 clock,
   input  wire logic                 rd_en,
   input  wire pir_pkg::key_type     rd_addr,
   output pir_pkg::id_type           rd_data,
   input  wire pir_pkg::pair_wr_type wr
);
   import pir_pkg::*;

   id_type mem [1 << KEY_W];
   id_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/pir_rev_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module pir_rev_mem (
   input  wire logic                clock,
   input  wire logic                rd_en,
   input  wire pir_pkg::id_type     rd_addr,
   output pir_pkg::key_type         rd_data,
   input  wire pir_pkg::rev_wr_type wr
);
   import pir_pkg::*;

   key_type mem [REV_DEPTH];
   key_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> test/partition_intersect_renumber_tb.sv
`timescale 1ns / 1ps

module partition_intersect_renumber_tb;
   import pir_pkg::*;

   localparam int ITEM_TOTAL   = 1550;
   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES  = 400;

   typedef enum int {
      SHAPE_DISTINCT,
      SHAPE_SINGLE,
      SHAPE_CLUSTERED,
      SHAPE_SCATTERED
   } pass_shape_type;

   typedef struct packed {
      id_type    merged_class;
      count_type class_count;
      logic      last;
   } class_result_type;

   // Tracks the intersection partition built so far in the current pass and
   // the results still owed by the block.
   class class_scoreboard;
      id_type           pass_ids[key_type];
      count_type        issued;
      pos_type          position;
      class_result_type owed[$];
      int               mismatches;

      function new();
         issued     = '0;
         position   = '0;
         mismatches = 0;
      endfunction

      function class_result_type refine_char(class_type own, class_type other);
         key_type          key;
         class_result_type r;
         key = {own, other};
         if (pass_ids.exists(key)) begin
            r.merged_class = pass_ids[key];
         end else begin
            r.merged_class = id_type'(issued);
            pass_ids[key]  = r.merged_class;
            issued         = issued + 1'b1;
         end
         r.class_count = issued;
         r.last        = (position >= LAST_POS);
         if (r.last) begin
            pass_ids.delete();
            issued   = '0;
            position = '0;
         end else begin
            position = position + 1'b1;
         end
         return r;
      endfunction

      function void note_char(class_type own, class_type other);
         owed.push_back(refine_char(own, other));
      endfunction

      function void check_result(id_type merged, count_type count, logic last);
         class_result_type want;
         if (owed.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual class %0d count %0d last %0b",
                     $time, merged, count, last);
            mismatches++;
            return;
         end
         want = owed.pop_front();
         if (merged !== want.merged_class) begin
            $display("%0t: merged_class expected %0d actual %0d",
                     $time, want.merged_class, merged);
            mismatches++;
         end
         if (count !== want.class_count) begin
            $display("%0t: class_count expected %0d actual %0d",
                     $time, want.class_count, count);
            mismatches++;
         end
         if (last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, last);
            mismatches++;
         end
      endfunction

      function int pending();
         return owed.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   quiet;
   bit   hold_go;
   int   cycles;

   pir_req_if req_ch ();
   pir_rsp_if rsp_ch ();

   class_scoreboard board = new();

   partition_intersect_renumber u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > LIMIT_CYCLES) begin
            $display("partition_intersect_renumber_tb failed");
            $finish;
         end
      end
   end

   // Result monitor: values are taken at the rising edge, before the block updates.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            board.check_result(rsp_ch.merged_class, rsp_ch.class_count, rsp_ch.last);
      end
   end

   // Receiver: random back-pressure, plus one long hold-off counted here.
   initial begin
      int hold_left;
      bit hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (quiet) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= 6);
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_char(input class_type own, input class_type other);
      while (!quiet && $urandom_range(99) < 6) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.own_class   <= own;
      req_ch.other_class <= other;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_char(own, other);
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (board.pending() != 0) @(negedge clock);
   endtask

   initial begin
      pass_shape_type shape;
      class_type      own, other;
      class_type      own_base, other_base, own_mask;
      int             own_span, other_span;
      int             pos, pass_no;

      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.own_class   = '0;
      req_ch.other_class = '0;
      quiet              = 1'b0;
      hold_go            = 1'b0;
      shape              = SHAPE_CLUSTERED;
      own_base = '0; other_base = '0; own_mask = '0;
      own_span = 0; other_span = 0;

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int n = 0; n < ITEM_TOTAL; n++) begin
         pos     = n % ALPHABET;
         pass_no = n / ALPHABET;
         if (pos == 0) begin
            case (pass_no)
               0:       shape = SHAPE_CLUSTERED;
               1:       shape = SHAPE_DISTINCT;
               2:       shape = SHAPE_SINGLE;
               3:       shape = SHAPE_CLUSTERED;
               4:       shape = SHAPE_SCATTERED;
               5:       shape = SHAPE_DISTINCT;
               default: shape = pass_shape_type'($urandom_range(3));
            endcase
            own_span   = $urandom_range(15);
            other_span = $urandom_range(15);
            own_base   = class_type'($urandom_range(255 - own_span));
            other_base = class_type'($urandom_range(255 - other_span));
            own_mask   = class_type'($urandom);
            // One pass runs with no idling on either side.
            quiet = (pass_no == 1);
         end
         // Sender pauses until the block has returned everything owed.
         if ((pass_no == 3 && pos == 0) || (pass_no == 4 && pos == 100))
            wait_for_drain();
         if (pass_no == 3 && pos == 20)
            hold_go = 1'b1;

         case (shape)
            SHAPE_DISTINCT: begin
               own   = class_type'(pos) ^ own_mask;
               other = class_type'($urandom);
            end
            SHAPE_SINGLE: begin
               own   = own_base;
               other = other_base;
            end
            SHAPE_CLUSTERED: begin
               own   = own_base + class_type'($urandom_range(own_span));
               other = other_base + class_type'($urandom_range(other_span));
            end
            default: begin
               own   = class_type'($urandom);
               other = class_type'($urandom);
            end
         endcase

         // Opening characters: field extremes, repeated pairs and swapped pairs.
         case (n)
            0:  {own, other} = {8'h00, 8'h00};
            1:  {own, other} = {8'hff, 8'hff};
            2:  {own, other} = {8'h00, 8'hff};
            3:  {own, other} = {8'hff, 8'h00};
            4:  {own, other} = {8'h00, 8'h00};
            5:  {own, other} = {8'hff, 8'hff};
            6:  {own, other} = {8'h55, 8'haa};
            7:  {own, other} = {8'haa, 8'h55};
            8:  {own, other} = {8'h55, 8'haa};
            9:  {own, other} = {8'h01, 8'h02};
            10: {own, other} = {8'h02, 8'h01};
            11: {own, other} = {8'h80, 8'h7f};
            12: {own, other} = {8'h7f, 8'h80};
            13: {own, other} = {8'h00, 8'hff};
            14: {own, other} = {8'hff, 8'h00};
            15: {own, other} = {8'h80, 8'h7f};
            default: ;
         endcase

         send_char(own, other);
      end

      quiet = 1'b0;
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("partition_intersect_renumber_tb passed");
      end else begin
         $display("partition_intersect_renumber_tb failed");
      end
      $finish;
   end

endmodule
